// File: src/glgp_pkg.sv
package glgp_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int SAMPLE_W     = 16;
  localparam int LEN_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAIN_LEN = 1'd1;

  typedef struct packed {
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic                       re;
    logic [ADDR_W-1:0]          raddr;
  } mem_req_t;

endpackage

// File: src/glgp_hist_mem.sv
module glgp_hist_mem (
  input  logic                                clk,
  input  logic                                rst_n,
  input  glgp_pkg::mem_req_t                  req,
  output logic signed [glgp_pkg::SAMPLE_W-1:0] rd_data
);

  logic signed [glgp_pkg::SAMPLE_W-1:0] mem [glgp_pkg::BUFFER_DEPTH];
  logic signed [glgp_pkg::SAMPLE_W-1:0] rd_q_r;
  logic signed [glgp_pkg::SAMPLE_W-1:0] fwd_r;
  logic                                 use_fwd_r;
  logic                                 use_mem_r;
  logic [glgp_pkg::FILL_W-1:0]          fill_r;
  logic [glgp_pkg::FILL_W-1:0]          fill_nxt;
  logic                                 same_addr;
  logic                                 was_written;

  // writes run sequentially from address zero, so entries below fill_r
  // are the only ones ever written since reset; the rest read as zero
  assign same_addr   = req.we && (req.raddr == req.waddr);
  assign was_written = {{(glgp_pkg::FILL_W-glgp_pkg::ADDR_W){1'b0}}, req.raddr} < fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (req.we && (fill_r != glgp_pkg::FILL_W'(glgp_pkg::BUFFER_DEPTH))) begin
      fill_nxt = fill_r + glgp_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r    <= mem[req.raddr];
      fwd_r     <= req.wdata;
      use_fwd_r <= same_addr;
      use_mem_r <= was_written && !same_addr;
    end
  end

  always_comb begin
    priority if (use_fwd_r) begin
      rd_data = fwd_r;
    end else if (use_mem_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// File: src/glgp_grain_seq.sv
module glgp_grain_seq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  logic signed [glgp_pkg::SAMPLE_W-1:0] sample,
  input  logic [glgp_pkg::LEN_W-1:0]           grain_length,
  output glgp_pkg::mem_req_t                   req,
  output logic                                 play
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PLAY = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  localparam int AW    = glgp_pkg::ADDR_W;
  localparam int CMP_W = (AW > glgp_pkg::LEN_W) ? AW : glgp_pkg::LEN_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(glgp_pkg::BUFFER_DEPTH - 1);
  localparam logic [AW:0]      DEPTH_X = (AW+1)'(glgp_pkg::BUFFER_DEPTH);

  logic [1:0]    phase_r, phase_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] len_r, len_nxt;

  logic [CMP_W-1:0] len_ext;
  logic [AW-1:0]    len_sat;
  logic [AW:0]      start_diff;
  logic [AW:0]      idx_sum;
  logic [AW:0]      count_inc;
  logic             enter;
  logic             play_now;

  assign len_ext = {{(CMP_W-glgp_pkg::LEN_W){1'b0}}, grain_length};
  assign len_sat = (len_ext > MAX_LEN) ? AW'(MAX_LEN) : AW'(len_ext);
  assign enter   = (phase_r != PH_PLAY) && (phase_r != PH_SKIP);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    wpos_nxt   = wpos_r;
    play_now   = 1'b0;
    start_diff = '0;
    idx_sum    = '0;
    count_inc  = '0;
    if (step) begin
      wpos_nxt = (wpos_r == AW'(glgp_pkg::BUFFER_DEPTH - 1)) ? '0 : wpos_r + AW'(1);
      if (enter) begin
        start_diff = {1'b0, wpos_nxt} - {1'b0, len_sat};
        if (wpos_nxt < len_sat) begin
          start_diff = start_diff + DEPTH_X;
        end
        len_nxt   = len_sat;
        start_nxt = start_diff[AW-1:0];
        count_nxt = '0;
        phase_nxt = PH_PLAY;
      end
      if (phase_nxt == PH_PLAY) begin
        play_now  = count_nxt < len_nxt;
        idx_sum   = {1'b0, start_nxt} + {1'b0, count_nxt};
        if (idx_sum >= DEPTH_X) begin
          idx_sum = idx_sum - DEPTH_X;
        end
        count_inc = {1'b0, count_nxt} + (AW+1)'(play_now);
        if (count_inc >= {1'b0, len_nxt}) begin
          phase_nxt = PH_SKIP;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc[AW-1:0];
        end
      end else begin
        count_inc = {1'b0, count_nxt} + (AW+1)'(1);
        if (count_inc >= {1'b0, len_nxt}) begin
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wpos_r  <= '0;
      count_r <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      wpos_r  <= wpos_nxt;
      count_r <= count_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  always_comb begin
    req.we    = step;
    req.waddr = wpos_r;
    req.wdata = sample;
    req.re    = play_now;
    req.raddr = idx_sum[AW-1:0];
  end

  assign play = play_now;

endmodule

// File: src/granular_loop_grain_player_unit.sv
// Granular grain player: each accepted sample is recorded, while enabled,
// into a circular history memory and answered by exactly one result, either
// a replayed past sample (in_grain high) or silence. Grains alternate between
// replaying the last grain_length samples and an equally long silent gap.
// One sample is taken per clock cycle unless the output stalls; a result
// passes through the registered memory read and then the output register.
// The memory needs no clearing pass after reset: a fill count marks unwritten
// entries, which read as zero. The user must write configuration only while
// the block holds no pending sample; the block does not enforce it.
module granular_loop_grain_player_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [15:0]                           in_tdata,   // [15:0] sample_in
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [15:0]                           out_tdata,  // [15:0] sample_out
  output logic                                  out_tuser,  // [0] in_grain
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [glgp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [glgp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic                                 enable_r;
  logic [glgp_pkg::LEN_W-1:0]           grain_len_r;
  logic                                 in_xfer;
  logic                                 step;
  logic                                 play;
  logic                                 advance;
  logic                                 s1_valid_r;
  logic                                 s1_play_r;
  logic                                 out_valid_r;
  logic signed [glgp_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                 out_grain_r;
  logic signed [glgp_pkg::SAMPLE_W-1:0] rd_data;
  glgp_pkg::mem_req_t                   req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      grain_len_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        glgp_pkg::REG_ENABLE:    enable_r    <= cfg_data[0];
        glgp_pkg::REG_GRAIN_LEN: grain_len_r <= cfg_data[glgp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign step      = in_xfer && enable_r;

  glgp_grain_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .sample       (in_tdata),
    .grain_length (grain_len_r),
    .req          (req),
    .play         (play)
  );

  glgp_hist_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  // stage 1 waits on the memory read; read data holds while it stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_play_r <= play;
    end
    if (advance && s1_valid_r) begin
      out_sample_r <= s1_play_r ? rd_data : '0;
      out_grain_r  <= s1_play_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_grain_r;

endmodule

// File: sim/granular_loop_grain_player_unit_tb.sv
module granular_loop_grain_player_unit_tb;

  localparam int BUFFER_DEPTH = glgp_pkg::BUFFER_DEPTH;
  localparam int ADDR_W       = glgp_pkg::ADDR_W;
  localparam int SAMPLE_W     = glgp_pkg::SAMPLE_W;
  localparam int LEN_W        = glgp_pkg::LEN_W;
  localparam int CFG_IDX_W    = glgp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = glgp_pkg::CFG_DATA_W;

  typedef enum logic [1:0] {
    GP_IDLE = 2'd0,
    GP_PLAY = 2'd1,
    GP_SKIP = 2'd2
  } grain_phase_e;

  typedef enum logic {
    ROW_SMP = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                grain;
  } grain_out_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [SAMPLE_W-1:0]   smp;
    logic                  typed;
    grain_out_t            res;
  } row_t;

  localparam int NDIR = 27;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] sample_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;  // [15:0] sample_out
  logic                  out_tuser;  // [0] in_grain
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  granular_loop_grain_player_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // grain player shadow state
  logic [SAMPLE_W-1:0] hist_mem [BUFFER_DEPTH];
  logic [ADDR_W-1:0]   wr_ptr;
  grain_phase_e        gphase;
  logic [LEN_W-1:0]    gcount;
  logic [LEN_W-1:0]    gstart;
  logic [LEN_W-1:0]    glen;
  logic                en_reg;
  logic [LEN_W-1:0]    len_reg;

  grain_out_t grain_out_q [$];
  int         errors = 0;
  bit         no_idle = 1'b0;

  row_t dir_rows [NDIR] = '{
    // disabled after reset: silent
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h7fff, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h8000, 1'b1, '{16'h0000, 1'b0}},
    // zero length grain: nothing played
    '{ROW_CFG, glgp_pkg::REG_ENABLE,    12'd1, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h7fff, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h8000, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h0000, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_CFG, glgp_pkg::REG_GRAIN_LEN, 12'd1, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h1234, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'hffff, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h0001, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_CFG, glgp_pkg::REG_GRAIN_LEN, 12'd3, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'ha5a5, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h5a5a, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h8000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h7fff, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'hffff, 1'b0, '{16'h0000, 1'b0}},
    // length change inside a running grain
    '{ROW_CFG, glgp_pkg::REG_GRAIN_LEN, 12'd5, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h0f0f, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'hf0f0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h7ffe, 1'b0, '{16'h0000, 1'b0}},
    // disable mid grain: silent, state frozen
    '{ROW_CFG, glgp_pkg::REG_ENABLE,    12'd0, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h1111, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h2222, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_CFG, glgp_pkg::REG_ENABLE,    12'd1, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h3333, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SMP, glgp_pkg::REG_ENABLE,    12'd0, 16'h4444, 1'b0, '{16'h0000, 1'b0}}
  };

  function automatic grain_out_t play_grain_step(input logic [SAMPLE_W-1:0] smp);
    grain_out_t res;
    int         len;
    res = '0;
    if (en_reg) begin
      hist_mem[wr_ptr] = smp;
      wr_ptr = ADDR_W'((int'(wr_ptr) + 1) % BUFFER_DEPTH);
      if (gphase != GP_PLAY && gphase != GP_SKIP) begin
        len = (int'(len_reg) > BUFFER_DEPTH - 1) ? BUFFER_DEPTH - 1 : int'(len_reg);
        glen   = LEN_W'(len);
        gstart = ADDR_W'((int'(wr_ptr) + BUFFER_DEPTH - len) % BUFFER_DEPTH);
        gcount = '0;
        gphase = GP_PLAY;
      end
      if (gphase == GP_PLAY) begin
        if (gcount < glen) begin
          res.smp   = hist_mem[ADDR_W'((int'(gstart) + int'(gcount)) % BUFFER_DEPTH)];
          res.grain = 1'b1;
          gcount++;
        end
        if (gcount >= glen) begin
          gphase = GP_SKIP;
          gcount = '0;
        end
      end else begin
        gcount++;
        if (gcount >= glen) begin
          gphase = GP_IDLE;
          gcount = '0;
        end
      end
    end
    return res;
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input grain_out_t typed_res);
    grain_out_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = play_grain_step(smp);
    grain_out_q.push_back(typed ? typed_res : res);
  endtask

  // sender gap after a transfer; rarely hold off until all results are back
  task automatic idle_sender();
    if (!no_idle && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end else if ($urandom_range(299) == 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (grain_out_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grain_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == glgp_pkg::REG_ENABLE) en_reg = val[0];
    else len_reg = val[LEN_W-1:0];
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    grain_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (grain_out_q.size() == 0) begin
        $error("unexpected result: sample_out %h in_grain %b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = grain_out_q.pop_front();
        if (out_tdata !== want.smp) begin
          $error("sample_out: expected %h, got %h", want.smp, out_tdata);
          errors++;
        end
        if (out_tuser !== want.grain) begin
          $error("in_grain: expected %b, got %b", want.grain, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= no_idle || ($urandom_range(99) >= 24);
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int                    rand_items;
    int                    phase_items;
    int                    pick;
    logic [LEN_W-1:0]      len_pick;
    logic [CFG_DATA_W-1:0] en_word;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_ptr  = '0;
    gphase  = GP_IDLE;
    gcount  = '0;
    gstart  = '0;
    glen    = '0;
    en_reg  = 1'b0;
    len_reg = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
        idle_sender();
      end
    end

    rand_items = 0;
    while (rand_items < 1550) begin
      no_idle = (rand_items >= 600 && rand_items < 900);
      pick = $urandom_range(99);
      if (pick < 70) len_pick = LEN_W'($urandom_range(0, 24));
      else if (pick < 90) len_pick = LEN_W'($urandom_range(25, 300));
      else len_pick = '0;
      // enable ignores the upper data bits
      en_word    = CFG_DATA_W'($urandom);
      en_word[0] = ($urandom_range(99) < 85);
      pick = $urandom_range(2);
      if (pick != 1) write_reg(glgp_pkg::REG_GRAIN_LEN, CFG_DATA_W'(len_pick));
      if (pick != 0) write_reg(glgp_pkg::REG_ENABLE, en_word);
      phase_items = $urandom_range(40, 140);
      repeat (phase_items) begin
        push_sample(SAMPLE_W'($urandom), 1'b0, '0);
        idle_sender();
        rand_items++;
      end
    end
    no_idle = 1'b0;

    // longest grain last: it would otherwise hold the phase for thousands of samples
    write_reg(glgp_pkg::REG_GRAIN_LEN, '1);
    write_reg(glgp_pkg::REG_ENABLE, CFG_DATA_W'(1));
    do begin
      push_sample(SAMPLE_W'($urandom), 1'b0, '0);
      idle_sender();
    end while (!(gphase == GP_PLAY && glen == LEN_W'(BUFFER_DEPTH - 1)));
    repeat (40) begin
      push_sample(SAMPLE_W'($urandom), 1'b0, '0);
      idle_sender();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grain_out_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/glgp_pkg.sv
src/glgp_hist_mem.sv
src/glgp_grain_seq.sv
src/granular_loop_grain_player_unit.sv
sim/granular_loop_grain_player_unit_tb.sv
